/* rtl/cifa_pkg.sv */
// shared types, constants and helpers for the checked integer fold alu
// no dependencies
package cifa_pkg;

  localparam int W        = 64;
  localparam int VALUE_W  = 64;
  localparam int KIND_W   = 5;
  localparam int STATUS_W = 2;
  localparam int SH_W     = $clog2(W);
  localparam int H        = (W + 1) / 2;
  localparam int CNT_W    = $clog2(W);
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    K_ADD = 5'd0, K_SUB = 5'd1, K_MUL = 5'd2, K_DIV = 5'd3, K_MOD = 5'd4,
    K_AND = 5'd5, K_OR = 5'd6, K_XOR = 5'd7, K_SHL = 5'd8, K_SHR = 5'd9,
    K_EQ = 5'd10, K_NE = 5'd11, K_GT = 5'd12, K_LT = 5'd13, K_GE = 5'd14,
    K_LE = 5'd15, K_NEG = 5'd16, K_NOT = 5'd17
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2, ST_SHIFT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0, BK_MUL = 2'd1, BK_DIV = 2'd2, BK_FIN = 2'd3
  } bk_state_t;

  typedef struct packed {
    cls_t          cls;
    logic          is_mod;
    logic          neg_res;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [W-1:0]  val;
    status_t       st;
  } q_entry_t;

  function automatic logic [VALUE_W-1:0] sext(input logic [W-1:0] x);
    logic signed [VALUE_W-1:0] r;
    r = VALUE_W'($signed(x));
    return r;
  endfunction

endpackage

/* rtl/checked_integer_fold_alu.sv */
// top level of the checked integer fold alu
// instantiates cifa_front, cifa_fifo and cifa_back; uses cifa_pkg
//
// usage:
//   input beat: in_tuser = kind, in_tdata = left_value then right_value
//   result beat: out_tdata = value, out_tuser = status
//   one result beat for every input beat, in order
// operation classes:
//   the front decodes and folds add, sub, logic, shifts, compares, neg
//   and not; these pass the queue and the result register and sustain
//   one beat per cycle while the back is idle and the output is not held
//   multiply runs four 32x32 partial products in the back, which takes
//   no new beat until the product is in the result register
//   divide and modulo run a radix-2 loop of 64 steps in the back, which
//   likewise takes no new beat until the result is loaded
//   a 4-entry queue lets the front keep accepting while the back works
// reset: rst_n low clears queue, back state and output valid
// stall: a held output keeps its beat; the queue fills, then in_tready drops
module checked_integer_fold_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*cifa_pkg::VALUE_W-1:0]      in_tdata,  // left_value, right_value
  input  logic [cifa_pkg::KIND_W-1:0]         in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cifa_pkg::VALUE_W-1:0]        out_tdata, // value
  output logic [cifa_pkg::STATUS_W-1:0]       out_tuser  // status
);

  cifa_pkg::q_entry_t fe_entry, q_head;
  logic q_full, q_empty, q_pop, q_push;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  cifa_front u_front (
    .kind     (in_tuser),
    .operands (in_tdata),
    .entry    (fe_entry)
  );

  cifa_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (fe_entry),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  cifa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/cifa_front.sv */
// front part: decodes an input beat, folds the simple operations
// and prepares magnitudes for multiply and divide; uses cifa_pkg
module cifa_front (
  input  logic [cifa_pkg::KIND_W-1:0]    kind,
  input  logic [2*cifa_pkg::VALUE_W-1:0] operands,
  output cifa_pkg::q_entry_t             entry
);

  localparam int W = cifa_pkg::W;

  logic [W-1:0] a, b, s, d, minv, shr_v;
  logic         sa, sb, big;
  logic [cifa_pkg::SH_W-1:0] amt;

  always_comb begin
    a     = operands[W-1:0];
    b     = operands[cifa_pkg::VALUE_W+W-1:cifa_pkg::VALUE_W];
    sa    = a[W-1];
    sb    = b[W-1];
    s     = a + b;
    d     = a - b;
    minv  = {1'b1, {(W-1){1'b0}}};
    amt   = b[cifa_pkg::SH_W-1:0];
    big   = sb || (b >= W'(W));
    shr_v = W'($signed(a) >>> amt);

    entry         = '0;
    entry.cls     = cifa_pkg::CL_SIMPLE;
    entry.st      = cifa_pkg::ST_OK;
    entry.ma      = sa ? (~a + 1'b1) : a;
    entry.mb      = sb ? (~b + 1'b1) : b;
    entry.neg_res = sa ^ sb;

    case (cifa_pkg::kind_t'(kind))
      cifa_pkg::K_ADD: begin
        if (((a ^ s) & (b ^ s) & minv) != '0) entry.st = cifa_pkg::ST_OVF;
        else entry.val = s;
      end
      cifa_pkg::K_SUB: begin
        if (((a ^ b) & (a ^ d) & minv) != '0) entry.st = cifa_pkg::ST_OVF;
        else entry.val = d;
      end
      cifa_pkg::K_MUL: entry.cls = cifa_pkg::CL_MUL;
      cifa_pkg::K_DIV: begin
        if (b == '0) entry.st = cifa_pkg::ST_DIV0;
        else if (a == minv && b == '1) entry.st = cifa_pkg::ST_OVF;
        else entry.cls = cifa_pkg::CL_DIV;
      end
      cifa_pkg::K_MOD: begin
        if (b == '0) entry.st = cifa_pkg::ST_DIV0;
        else begin
          entry.cls     = cifa_pkg::CL_DIV;
          entry.is_mod  = 1'b1;
          entry.neg_res = sa;
        end
      end
      cifa_pkg::K_AND: entry.val = a & b;
      cifa_pkg::K_OR:  entry.val = a | b;
      cifa_pkg::K_XOR: entry.val = a ^ b;
      cifa_pkg::K_SHL: begin
        if (big) entry.st = cifa_pkg::ST_SHIFT;
        else entry.val = a << amt;
      end
      cifa_pkg::K_SHR: begin
        if (big) entry.st = cifa_pkg::ST_SHIFT;
        else entry.val = shr_v;
      end
      cifa_pkg::K_EQ: entry.val = W'(a == b);
      cifa_pkg::K_NE: entry.val = W'(a != b);
      cifa_pkg::K_GT: entry.val = W'($signed(a) > $signed(b));
      cifa_pkg::K_LT: entry.val = W'($signed(a) < $signed(b));
      cifa_pkg::K_GE: entry.val = W'($signed(a) >= $signed(b));
      cifa_pkg::K_LE: entry.val = W'($signed(a) <= $signed(b));
      cifa_pkg::K_NEG: begin
        if (a == minv) entry.st = cifa_pkg::ST_OVF;
        else entry.val = ~a + 1'b1;
      end
      cifa_pkg::K_NOT: entry.val = ~a;
      default: entry.st = cifa_pkg::ST_OVF;
    endcase
  end

endmodule

/* rtl/cifa_fifo.sv */
// short queue of decoded beats between front and back parts
// uses cifa_pkg
module cifa_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cifa_pkg::q_entry_t wdata,
  output logic               full,
  input  logic               pop,
  output cifa_pkg::q_entry_t rdata,
  output logic               empty
);

  localparam int PW = cifa_pkg::FQ_PTR_W;

  cifa_pkg::q_entry_t mem [cifa_pkg::FQ_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(cifa_pkg::FQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= wdata;
  end

endmodule

/* rtl/cifa_back.sv */
// back part: multi-cycle multiply and divide, result register
// uses cifa_pkg
module cifa_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             empty,
  input  cifa_pkg::q_entry_t               head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cifa_pkg::VALUE_W-1:0]     out_tdata,
  output logic [cifa_pkg::STATUS_W-1:0]    out_tuser
);

  localparam int W  = cifa_pkg::W;
  localparam int H  = cifa_pkg::H;
  localparam int CW = cifa_pkg::CNT_W;

  cifa_pkg::bk_state_t state_r, state_nxt;

  logic [W-1:0]   op_a_r, op_b_r, rem_r, quo_r;
  logic           is_mod_r, neg_r, is_mul_r;
  logic [2:0]     mcnt_r;
  logic [1:0]     psel_r;
  logic [2*H-1:0] prod_r;
  logic [4*H-1:0] acc_r, addend;
  logic [CW-1:0]  dcnt_r;
  logic [2*H-1:0] pa, pb;
  logic [H-1:0]   fa, fb;
  logic [W:0]     trial;
  logic           ge;

  logic                             out_valid_r;
  logic [cifa_pkg::VALUE_W-1:0]     out_value_r;
  cifa_pkg::status_t                out_status_r;

  logic              out_free, load_out;
  logic [W-1:0]      lval, lo, limit, res;
  cifa_pkg::status_t lst;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    pa = (2*H)'(op_a_r);
    pb = (2*H)'(op_b_r);
    case (mcnt_r[1:0])
      2'd0:    begin fa = pa[H-1:0];   fb = pb[H-1:0];   end
      2'd1:    begin fa = pa[H-1:0];   fb = pb[2*H-1:H]; end
      2'd2:    begin fa = pa[2*H-1:H]; fb = pb[H-1:0];   end
      default: begin fa = pa[2*H-1:H]; fb = pb[2*H-1:H]; end
    endcase
    case (psel_r)
      2'd0:    addend = (4*H)'(prod_r);
      2'd3:    addend = (4*H)'(prod_r) << (2*H);
      default: addend = (4*H)'(prod_r) << H;
    endcase
    trial = {rem_r, quo_r[W-1]};
    ge    = (trial >= {1'b0, op_b_r});
  end

  always_comb begin
    lo    = acc_r[W-1:0];
    limit = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    res   = '0;
    lst   = cifa_pkg::ST_OK;
    if (is_mul_r) begin
      if ((|acc_r[4*H-1:W]) || lo > limit) lst = cifa_pkg::ST_OVF;
      else res = neg_r ? (~lo + 1'b1) : lo;
    end else if (is_mod_r) begin
      res = neg_r ? (~rem_r + 1'b1) : rem_r;
    end else begin
      res = neg_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    lval      = head.val;
    case (state_r)
      cifa_pkg::BK_IDLE: begin
        if (!empty) begin
          case (head.cls)
            cifa_pkg::CL_MUL: begin
              pop       = 1'b1;
              state_nxt = cifa_pkg::BK_MUL;
            end
            cifa_pkg::CL_DIV: begin
              pop       = 1'b1;
              state_nxt = cifa_pkg::BK_DIV;
            end
            default: begin
              if (out_free) begin
                pop      = 1'b1;
                load_out = 1'b1;
              end
            end
          endcase
        end
      end
      cifa_pkg::BK_MUL: begin
        if (mcnt_r == 3'd4) state_nxt = cifa_pkg::BK_FIN;
      end
      cifa_pkg::BK_DIV: begin
        if (dcnt_r == CW'(W-1)) state_nxt = cifa_pkg::BK_FIN;
      end
      cifa_pkg::BK_FIN: begin
        lval = res;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = cifa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cifa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cifa_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (pop) begin
        mcnt_r <= '0;
        dcnt_r <= '0;
      end else begin
        if (state_r == cifa_pkg::BK_MUL) mcnt_r <= mcnt_r + 1'b1;
        if (state_r == cifa_pkg::BK_DIV) dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == cifa_pkg::BK_FIN) begin
        out_status_r <= lst;
        out_value_r  <= (lst == cifa_pkg::ST_OK) ? cifa_pkg::sext(lval) : '0;
      end else begin
        out_status_r <= head.st;
        out_value_r  <= (head.st == cifa_pkg::ST_OK) ? cifa_pkg::sext(lval) : '0;
      end
    end
    if (pop) begin
      op_a_r   <= head.ma;
      op_b_r   <= head.mb;
      is_mod_r <= head.is_mod;
      neg_r    <= head.neg_res;
      is_mul_r <= (head.cls == cifa_pkg::CL_MUL);
      acc_r    <= '0;
      rem_r    <= '0;
      quo_r    <= head.ma;
    end
    if (state_r == cifa_pkg::BK_MUL) begin
      if (mcnt_r != 3'd4) begin
        prod_r <= fa * fb;
        psel_r <= mcnt_r[1:0];
      end
      if (mcnt_r != 3'd0) acc_r <= acc_r + addend;
    end
    if (state_r == cifa_pkg::BK_DIV) begin
      rem_r <= ge ? W'(trial - {1'b0, op_b_r}) : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cifa_pkg::BK_IDLE) |-> !pop)
    else $error("queue popped while back part busy");

  a_mcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cifa_pkg::BK_MUL) |-> (mcnt_r <= 3'd4))
    else $error("multiply step count out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cifa_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("failed fold carries a nonzero value");

endmodule
